// ===== design/cdtp_pkg.sv =====
// Shared types, character codes and helpers for the decimal token parser.
`timescale 1ns / 1ps

package cdtp_pkg;

   localparam int MAG_W       = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [CSR_INDEX_W-1:0] CSR_NEG_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_MAX    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEG_MAX    = 2'd2;

   localparam logic [MAG_W-1:0] POS_MAX_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [MAG_W-1:0] NEG_MAX_RESET = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      ST_VALID    = 2'd0,
      ST_INVALID  = 2'd1,
      ST_NO_TOKEN = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } rsp_type;

   typedef struct packed {
      logic             neg_enable;
      logic [MAG_W-1:0] pos_max;
      logic [MAG_W-1:0] neg_max;
   } cfg_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

// ===== design/checked_decimal_token_parser.sv =====
// Top level of the checked decimal token parser: handshakes, stage registers, checks.
`timescale 1ns / 1ps

// An accepted beat waits in the input register until the result stage can take it;
//   its result, if any, is then registered in the result register behind rsp_valid.
// Throughput: one byte per cycle; the token state loop (times-ten add and a 68-bit
//   limit compare) is purely combinational, so the only stall source is rsp_stall.
// Reset: synchronous, active high; clears token state, both valid flags and loads
//   the register defaults (negatives allowed, signed 64-bit limits).
module checked_decimal_token_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cdtp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cdtp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cdtp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cdtp_pkg::MAG_W-1:0]         csr_wdata
);
   import cdtp_pkg::*;

   // Input stage: one beat waiting to be parsed.
   logic    in_valid_ff, in_valid_in;
   req_type in_beat_ff;

   // Result stage: one result beat waiting for the consumer.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic    advance;
   logic    req_accept;
   logic    step;
   logic    emit;
   rsp_type result;
   cfg_type cfg;

   // The result register can take a new beat when it is empty or being drained.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   // Hold the input only when a parsed beat cannot move on.
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign step       = in_valid_ff && advance;

   // Register writes are always taken; software is to write only while idle, not enforced here.
   assign csr_ready = 1'b1;

   cdtp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   cdtp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .beat   (in_beat_ff),
      .cfg    (cfg),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;   // beat taken, nothing new behind it
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset, load only on a moving beat.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_beat_ff <= req_data;
      end
      if (step && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A parked input beat must survive until the result stage frees up.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input beat lost while result stage was blocked");

   // Backpressure upstream only comes from a stalled, full result stage.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without output backpressure");

   // Invalid tokens and empty ends carry no magnitude.
   a_zero_magnitude: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == ST_INVALID || rsp_data_ff.status == ST_NO_TOKEN))
      |-> (rsp_data_ff.magnitude == '0))
      else $error("magnitude set on a non-valid result");

   // A no-token result never reports a sign.
   a_no_token_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ST_NO_TOKEN) |-> !rsp_data_ff.negative)
      else $error("sign set on a no-token result");

endmodule

// ===== design/cdtp_csr.sv =====
// Configuration registers of the decimal token parser.
`timescale 1ns / 1ps

module cdtp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [cdtp_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [cdtp_pkg::MAG_W-1:0]         wr_data,
   output cdtp_pkg::cfg_type                  cfg
);
   import cdtp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_NEG_ENABLE: cfg_in.neg_enable = wr_data[0];
            CSR_POS_MAX:    cfg_in.pos_max    = wr_data;
            CSR_NEG_MAX:    cfg_in.neg_max    = wr_data;
            default: cfg_in = cfg_ff;   // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neg_enable <= 1'b1;
         cfg_ff.pos_max    <= POS_MAX_RESET;
         cfg_ff.neg_max    <= NEG_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/cdtp_engine.sv =====
// Token state and the per-byte update that yields at most one result.
`timescale 1ns / 1ps

module cdtp_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  cdtp_pkg::req_type beat,
   input  cdtp_pkg::cfg_type cfg,
   output logic              emit,
   output cdtp_pkg::rsp_type result
);
   import cdtp_pkg::*;

   logic             in_token_ff, in_token_in;
   logic [MAG_W-1:0] accum_ff, accum_in;
   logic             sign_neg_ff, sign_neg_in;
   logic             still_valid_ff, still_valid_in;
   logic             seen_digit_ff, seen_digit_in;

   logic [MAG_W+3:0] wide_accum;
   logic [MAG_W+3:0] candidate;
   logic [MAG_W-1:0] limit;
   logic [3:0]       digit_value;
   logic             over_limit;
   logic             token_ok;

   // accum*10 + d against the limit is the same test as comparing with limit/10 and limit%10
   assign limit       = (sign_neg_ff && cfg.neg_enable) ? cfg.neg_max : cfg.pos_max;
   assign digit_value = 4'(beat.char_byte - CHAR_ZERO);
   assign wide_accum  = {4'b0000, accum_ff};
   assign candidate   = (wide_accum << 3) + (wide_accum << 1) + {{MAG_W{1'b0}}, digit_value};
   assign over_limit  = candidate > {4'b0000, limit};
   assign token_ok    = still_valid_ff && seen_digit_ff;

   always_comb begin
      in_token_in    = in_token_ff;
      accum_in       = accum_ff;
      sign_neg_in    = sign_neg_ff;
      still_valid_in = still_valid_ff;
      seen_digit_in  = seen_digit_ff;
      emit           = 1'b0;
      result.status    = token_ok ? ST_VALID : ST_INVALID;
      result.negative  = sign_neg_ff;
      result.magnitude = token_ok ? accum_ff : '0;

      if (beat.stream_end || is_blank(beat.char_byte)) begin
         if (!in_token_ff && beat.stream_end) begin
            result.status    = ST_NO_TOKEN;
            result.negative  = 1'b0;
            result.magnitude = '0;
         end
         emit           = beat.stream_end || in_token_ff;
         in_token_in    = 1'b0;
         accum_in       = '0;
         sign_neg_in    = 1'b0;
         still_valid_in = 1'b1;
         seen_digit_in  = 1'b0;
      end else begin
         in_token_in = 1'b1;
         if (!in_token_ff && (beat.char_byte == CHAR_PLUS || beat.char_byte == CHAR_MINUS)) begin
            sign_neg_in = (beat.char_byte == CHAR_MINUS);
            if (sign_neg_in && !cfg.neg_enable) begin
               still_valid_in = 1'b0;
            end
         end else if (is_digit(beat.char_byte)) begin
            seen_digit_in = 1'b1;
            if (over_limit) begin
               still_valid_in = 1'b0;   // drop the digit, hold the value
            end else begin
               accum_in = candidate[MAG_W-1:0];
            end
         end else begin
            still_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff    <= 1'b0;
         accum_ff       <= '0;
         sign_neg_ff    <= 1'b0;
         still_valid_ff <= 1'b1;
         seen_digit_ff  <= 1'b0;
      end else if (step) begin
         in_token_ff    <= in_token_in;
         accum_ff       <= accum_in;
         sign_neg_ff    <= sign_neg_in;
         still_valid_ff <= still_valid_in;
         seen_digit_ff  <= seen_digit_in;
      end
   end

endmodule

// ===== test/tb_checked_decimal_token_parser.sv =====
// Testbench for checked_decimal_token_parser: byte streams checked against a token predictor.
`timescale 1ns / 1ps

module tb_checked_decimal_token_parser;
   import cdtp_pkg::*;

   // Whitespace codes that the package does not name.
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   // Register index with nothing behind it; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   // A result passes the input and result stage registers after its beat is taken; wait a bit longer.
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 200;
   localparam int PHASE_BEATS  = 285;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_NEG_ENABLE;
   logic [MAG_W-1:0]       csr_wdata = '0;

   checked_decimal_token_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Token predictor: its own copy of the registers and the token state.
   // ------------------------------------------------------------------
   logic             cfg_allow_neg = 1'b1;
   logic [MAG_W-1:0] cfg_pos_limit = POS_MAX_RESET;
   logic [MAG_W-1:0] cfg_neg_limit = NEG_MAX_RESET;

   logic             tok_open  = 1'b0;
   logic [MAG_W-1:0] tok_accum = '0;
   logic             tok_minus = 1'b0;
   logic             tok_ok    = 1'b1;
   logic             tok_digit = 1'b0;

   rsp_type     pending_results[$];
   int unsigned errors     = 0;
   int unsigned beats_sent = 0;

   function automatic logic blank_char(input logic [7:0] c);
      case (c)
         CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Close the open token: queue its result and return to the between-tokens state.
   task automatic emit_token();
      rsp_type res;
      res           = '0;
      res.status    = (tok_ok && tok_digit) ? ST_VALID : ST_INVALID;
      res.negative  = tok_minus;
      res.magnitude = (tok_ok && tok_digit) ? tok_accum : '0;
      pending_results.push_back(res);
      tok_open  = 1'b0;
      tok_accum = '0;
      tok_minus = 1'b0;
      tok_ok    = 1'b1;
      tok_digit = 1'b0;
   endtask

   // Advance the token state by one accepted beat.
   task automatic parse_char(input req_type beat);
      rsp_type          res;
      logic [MAG_W-1:0] lim, quo, rem, dig;
      logic             done;
      done = 1'b0;
      if (beat.stream_end) begin
         if (tok_open) begin
            emit_token();
         end else begin
            res        = '0;
            res.status = ST_NO_TOKEN;
            pending_results.push_back(res);
         end
      end else if (blank_char(beat.char_byte)) begin
         if (tok_open) emit_token();
      end else begin
         // A sign counts only as the opening byte of a token.
         if (!tok_open) begin
            tok_open = 1'b1;
            if (beat.char_byte == CHAR_PLUS || beat.char_byte == CHAR_MINUS) begin
               tok_minus = (beat.char_byte == CHAR_MINUS);
               if (tok_minus && !cfg_allow_neg) tok_ok = 1'b0;
               done = 1'b1;
            end
         end
         if (!done) begin
            if (beat.char_byte >= CHAR_ZERO && beat.char_byte <= CHAR_NINE) begin
               lim = (tok_minus && cfg_allow_neg) ? cfg_neg_limit : cfg_pos_limit;
               quo = lim / 64'd10;
               rem = lim % 64'd10;
               dig = {56'd0, beat.char_byte - CHAR_ZERO};
               tok_digit = 1'b1;
               // An overflowing digit is dropped; the magnitude holds.
               if (tok_accum > quo || (tok_accum == quo && dig > rem))
                  tok_ok = 1'b0;
               else
                  tok_accum = tok_accum * 64'd10 + dig;
            end else begin
               tok_ok = 1'b0;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: compare every accepted result beat with the oldest
   // expectation, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.negative !== want.negative) begin
               $display("%0t: negative mismatch: expected %0b, actual %0b",
                        $time, want.negative, rsp_data.negative);
               errors++;
            end
            if (rsp_data.magnitude !== want.magnitude) begin
               $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                        $time, want.magnitude, rsp_data.magnitude);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall on a changing random pattern. A long hold-off can be
   // requested; it is counted here while the sender keeps offering beats.
   // ------------------------------------------------------------------
   int        hold_asked = 0;
   int        hold_given = 0;
   int        hold_left  = 0;
   int        mode_left  = 0;
   stall_type stall_mode = STALL_NONE;

   always @(negedge clock) begin
      if (hold_given != hold_asked) begin
         hold_given = hold_asked;
         hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 400);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
            default:     rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sender: offer one beat at a time, drop valid between bursts.
   // ------------------------------------------------------------------
   logic pace_on    = 1'b1;
   int   burst_left = 0;

   task automatic send_beat(input logic [7:0] char_in, input logic end_in);
      int gap;
      @(negedge clock);
      req_valid            <= 1'b1;
      req_data.char_byte   <= char_in;
      req_data.stream_end  <= end_in;
      do @(posedge clock); while (req_stall);
      parse_char(req_data);
      beats_sent++;
      if (pace_on) begin
         if (burst_left == 0) begin
            // Mostly short bursts, now and then a long run with no gap.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Send a value as decimal digits, optionally behind leading zeros.
   task automatic send_number(input logic [MAG_W-1:0] value, input int zeros);
      logic [7:0]       digits[20];
      logic [MAG_W-1:0] v, rem;
      int               n;
      v = value;
      n = 0;
      repeat (zeros) send_beat(CHAR_ZERO, 1'b0);
      do begin
         rem       = v % 64'd10;
         digits[n] = CHAR_ZERO + rem[7:0];
         v         = v / 64'd10;
         n++;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) send_beat(digits[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_LF;
         3: return CHAR_VT;
         4: return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic logic [MAG_W-1:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // Drop valid and wait until every expected result has come back, plus
   // DRAIN_CYCLES more, so no beat is still in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [MAG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_NEG_ENABLE: cfg_allow_neg = data[0];
         CSR_POS_MAX:    cfg_pos_limit = data;
         CSR_NEG_MAX:    cfg_neg_limit = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_registers(input logic [MAG_W-1:0] allow_word,
                                input logic [MAG_W-1:0] pos_limit,
                                input logic [MAG_W-1:0] neg_limit);
      wait_idle();
      write_register(CSR_NEG_ENABLE, allow_word);
      write_register(CSR_POS_MAX, pos_limit);
      write_register(CSR_NEG_MAX, neg_limit);
   endtask

   // One token of random shape, then its terminator.
   task automatic send_random_token();
      int               kind, sign_pick;
      logic             minus;
      logic [7:0]       odd;
      logic [MAG_W-1:0] lim, value;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         // Well-formed number, often right at the active limit.
         sign_pick = $urandom_range(0, 4);
         minus     = (sign_pick == 4);
         if (sign_pick == 3) send_beat(CHAR_PLUS, 1'b0);
         if (minus) send_beat(CHAR_MINUS, 1'b0);
         lim = (minus && cfg_allow_neg) ? cfg_neg_limit : cfg_pos_limit;
         case ($urandom_range(0, 5))
            0: value = 64'($urandom_range(0, 999));
            1: value = rnd64();
            2: value = lim;
            3: value = lim + 64'd1;  // wraps to zero at the top of the range
            4: value = lim - 64'd1;
            default: value = (lim == '1) ? rnd64() : rnd64() % (lim + 64'd1);
         endcase
         send_number(value, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
         // An occasional extra digit can push the value over, even past an all-ones limit.
         if ($urandom_range(0, 9) == 0)
            send_beat(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end else if (kind < 68) begin
         send_beat(($urandom_range(0, 1) != 0) ? CHAR_PLUS : CHAR_MINUS, 1'b0);
      end else if (kind < 80) begin
         // Digits followed by a random non-blank byte, digits may follow.
         send_number(64'($urandom_range(0, 99999)), 0);
         do odd = 8'($urandom_range(0, 255)); while (blank_char(odd));
         send_beat(odd, 1'b0);
         if ($urandom_range(0, 1) != 0) send_number(64'($urandom_range(0, 999)), 0);
      end else if (kind < 92) begin
         repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         repeat ($urandom_range(1, 3)) send_end();
      end
      if ($urandom_range(0, 6) == 0)
         send_end();
      else
         repeat ($urandom_range(1, 3)) send_beat(pick_blank(), 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: signs, stray bytes, end markers, every whitespace code.
   task automatic test_directed_tokens();
      send_text("+7");
      send_beat(CHAR_TAB, 1'b0);     // plain token with a plus sign
      send_beat(CHAR_MINUS, 1'b0);
      send_beat(CHAR_LF, 1'b0);      // sign with no digit
      send_text("1-2 ");             // sign inside the token
      send_beat(CHAR_FF, 1'b0);      // whitespace between tokens only
      send_end();                    // end marker with no token, twice
      send_end();
      send_text("0");
      send_end();                    // token closed by the end marker
      send_beat(8'hFF, 1'b0);
      send_beat(CHAR_VT, 1'b0);      // top byte value is a bad byte
      send_text("-0");
      send_beat(CHAR_CR, 1'b0);
   endtask

   // Overflow on the exact boundary digit, negative limit, forbidden minus.
   task automatic test_limit_edges();
      set_registers(64'd1, 64'd25, 64'd0);
      write_register(CSR_UNMAPPED, rnd64());
      send_text("26 25 -1 -0 ");
      wait_idle();
      write_register(CSR_NEG_ENABLE, 64'd0);
      send_text("-3 ");
   endtask

   // Hold the result side off for a long stretch while beats keep coming,
   // so the block fills and stalls its input.
   task automatic test_backpressure();
      set_registers(64'd1, POS_MAX_RESET, NEG_MAX_RESET);
      pace_on = 1'b0;
      hold_asked++;
      repeat (40) begin
         send_beat(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         send_beat(CHAR_SPACE, 1'b0);
      end
      pace_on = 1'b1;
   endtask

   // Random token streams under a series of register settings.
   task automatic test_random_streams();
      int unsigned phase_end;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_registers(64'd1, POS_MAX_RESET, NEG_MAX_RESET);
            1: set_registers(rnd64() & ~64'd1, '1, rnd64());
            2: set_registers(rnd64() | 64'd1, 64'd0, '1);
            3: set_registers(64'd1, 64'($urandom_range(0, 100000)),
                             64'($urandom_range(0, 100000)));
            4: set_registers(rnd64(), rnd64(), rnd64());
            default: set_registers(64'd1, 64'd0, 64'd0);
         endcase
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) send_random_token();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_tokens();
      test_limit_edges();
      test_backpressure();
      test_random_streams();
      wait_idle();

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: end a hung run.
   int unsigned cycle_count = 0;
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/cdtp_pkg.sv
design/cdtp_csr.sv
design/cdtp_engine.sv
design/checked_decimal_token_parser.sv
test/tb_checked_decimal_token_parser.sv
